/* hw/rtl/lrsd_pkg.sv */
// Package: shared types, codes and constant tables of the stream decompressor.
package lrsd_pkg;

	// Input and result words
	typedef struct packed {
		logic       func;
		logic [7:0] packed_byte;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] out_bytes;
		logic [3:0]  out_count;
		logic        signature_ok;
	} out_word_t;

	// Function codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_PULL = 1'b1;

	// Status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NEED     = 3'd1;
	localparam logic [2:0] ST_DONE     = 3'd2;
	localparam logic [2:0] ST_BAD_HDR  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	// Control codes of the code stream
	localparam logic [23:0] CODE_END   = 24'd0;
	localparam logic [23:0] CODE_RESET = 24'd1;
	localparam logic [23:0] CODE_WIDEN = 24'd2;
	localparam logic [23:0] CODE_RUN   = 24'd3;

	localparam logic [23:0] FIRST_ENTRY = 24'h104;
	localparam logic [11:0] SIG_OFFSET  = 12'h5E1;
	localparam logic [11:0] SIG_END     = 12'h600;
	localparam logic [11:0] POS_MAX     = 12'hFFF;
	localparam logic [4:0]  START_WIDTH = 5'd9;
	localparam logic [4:0]  MAX_WIDTH   = 5'd24;

	// Stream phase
	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_START   = 3'd1,
		PH_NORMAL  = 3'd2,
		PH_RUN_LEN = 3'd3,
		PH_RUN_WID = 3'd4,
		PH_RUN_CNT = 3'd5,
		PH_DONE    = 3'd6,
		PH_FAIL    = 3'd7
	} phase_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE, S_LOOP, S_PEND, S_LZW, S_CH_PS, S_CH_OFF, S_CH_HEAP, S_APPEND,
		S_CP_RD, S_CP_WR, S_TR, S_TR_OFF, S_TR_LEN, S_TR_RD, S_TR_WR, S_BRST
	} seq_t;

	// Header bytes
	function automatic logic [7:0] hdr_byte(input logic [3:0] i);
		logic [7:0] b;
		unique case (i)
			4'd0:  b = 8'h59;
			4'd1:  b = 8'h73;
			4'd2:  b = 8'h43;
			4'd3:  b = 8'h6F;
			4'd4:  b = 8'h6D;
			4'd5:  b = 8'h70;
			4'd6:  b = 8'h07;
			4'd7:  b = 8'h43;
			4'd8:  b = 8'h55;
			4'd9:  b = 8'h44;
			4'd10: b = 8'h31;
			4'd11: b = 8'h39;
			4'd12: b = 8'h39;
			4'd13: b = 8'h37;
			4'd14: b = 8'h1A;
			default: b = 8'h04;
		endcase
		return b;
	endfunction

	// Trailing signature bytes
	function automatic logic [7:0] sig_byte(input logic [4:0] i);
		logic [7:0] b;
		unique case (i)
			5'd0:  b = 8'h43;
			5'd1:  b = 8'h55;
			5'd2:  b = 8'h44;
			5'd3:  b = 8'h2D;
			5'd4:  b = 8'h46;
			5'd5:  b = 8'h4D;
			5'd6:  b = 8'h2D;
			5'd7:  b = 8'h46;
			5'd8:  b = 8'h69;
			5'd9:  b = 8'h6C;
			5'd10: b = 8'h65;
			5'd11: b = 8'h20;
			5'd12: b = 8'h2D;
			5'd13: b = 8'h20;
			5'd14: b = 8'h53;
			5'd15: b = 8'h45;
			5'd16: b = 8'h4E;
			5'd17: b = 8'h44;
			5'd18: b = 8'h20;
			5'd19: b = 8'h41;
			5'd20: b = 8'h20;
			5'd21: b = 8'h50;
			5'd22: b = 8'h4F;
			5'd23: b = 8'h53;
			5'd24: b = 8'h54;
			5'd25: b = 8'h43;
			5'd26: b = 8'h41;
			5'd27: b = 8'h52;
			5'd28: b = 8'h44;
			5'd29: b = 8'h20;
			5'd30: b = 8'h2D;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* hw/rtl/lrsd_stream_if.sv */
// Interface: valid/ready stream channel carrying one word.
interface lrsd_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/lzw_rle_stream_decompressor_unit.sv */
// Top level: LZW stream decompressor with run repeat, sequenced over shared memories.
//
// channel | dir | word         | fields
// in_ch   | in  | in_word_t    | func, packed_byte
// out_ch  | out | out_word_t   | status, out_bytes, out_count, signature_ok
//
// Each push or pull returns one result word; a pull packs up to 8 output bytes.
// Per dictionary code the sequencer copies the new entry into the string heap and
// then walks the translated string from the heap into the previous-string buffer.
// Reset clears all control state; the memories are not cleared.
// A new word is taken only when the sequencer is idle and the result register is empty.
module lzw_rle_stream_decompressor_unit #(
	parameter int HEAP_BYTES   = 65536,
	parameter int DICT_ENTRIES = 32768,
	parameter int MAX_STRING   = 255
) (
	input  logic  clk,
	input  logic  arst_n,
	lrsd_stream_if.sink   in_ch,
	lrsd_stream_if.source out_ch
);
	import lrsd_pkg::*;

	localparam int HAW = $clog2(HEAP_BYTES);
	localparam int HFW = HAW + 1;
	localparam int DAW = $clog2(DICT_ENTRIES);
	localparam int EW  = DAW + 1;
	localparam logic [HFW:0] HEAP_LIM  = (HFW+1)'(HEAP_BYTES);
	localparam logic [EW-1:0] DICT_LIM = EW'(DICT_ENTRIES);
	localparam logic [7:0] STR_LIM     = 8'(MAX_STRING);

	// Memories
	logic [7:0]     heap_q [HEAP_BYTES];
	logic [HAW-1:0] eo_q   [DICT_ENTRIES];
	logic [7:0]     ps_q   [256];
	logic [7:0]     heap_rd_q, ps_rd_q;
	logic [HAW-1:0] eo_rd_q;

	logic           heap_we, eo_we, ps_we;
	logic [HAW-1:0] heap_wa, heap_ra;
	logic [7:0]     heap_wd, ps_wd;
	logic [DAW-1:0] eo_wa, eo_ra;
	logic [HAW-1:0] eo_wd;
	logic [7:0]     ps_wa, ps_ra;

	// Control and data registers
	seq_t           state_q, state_d;
	phase_t         phase_q, phase_d;
	logic [39:0]    buf_q, buf_d;
	logic [5:0]     bcnt_q, bcnt_d;
	logic [4:0]     cw_q, cw_d;
	logic [EW-1:0]  ecnt_q, ecnt_d;
	logic [HFW-1:0] hfill_q, hfill_d;
	logic [7:0]     plen_q, plen_d;
	logic [7:0]     pend_q, pend_d;
	logic [34:0]    run_q, run_d;
	logic [31:0]    recent_q, recent_d;
	logic [11:0]    opos_q, opos_d;
	logic           sigm_q, sigm_d;
	logic [4:0]     hidx_q, hidx_d;
	logic [4:0]     skip_q, skip_d;
	logic [1:0]     rsym_q, rsym_d;
	logic [5:0]     rwid_q, rwid_d;
	logic [2:0]     fcode_q, fcode_d;
	logic [23:0]    code_q, code_d;
	logic [5:0]     before_q, before_d;
	logic [7:0]     ch_q, ch_d;
	logic [HAW-1:0] off_q, off_d;
	logic [7:0]     idx_q, idx_d;
	logic [63:0]    acc_q, acc_d;
	logic [3:0]     n_q, n_d;
	logic           ovalid_q, ovalid_d;
	out_word_t      oword_q, oword_d;

	// Shared shift unit and take logic
	logic [5:0]     sh_amt, take_w;
	logic [39:0]    sh_out;
	logic [31:0]    take_v, take_mask;
	logic           take_ok;
	logic [32:0]    mask_full;

	// Emit path
	logic           emit_en;
	logic [7:0]     emit_b;

	logic           fin, accept;
	logic [24:0]    next_code;
	logic [5:0]     drop;
	logic [2:0]     drop_lo;
	logic [7:0]     nl;
	logic [HFW:0]   heap_need;
	logic [39:0]    push_ext;
	logic [7:0]     lit;

	assign sh_out     = buf_q >> sh_amt;
	assign mask_full  = (33'd1 << take_w) - 33'd1;
	assign take_mask  = mask_full[31:0];
	assign take_v     = buf_q[31:0] & take_mask;
	assign take_ok    = bcnt_q >= take_w;
	assign next_code  = {1'b0, FIRST_ENTRY} + 25'(ecnt_q);
	assign drop_lo    = before_q[2:0] + 3'd7;
	assign drop       = 6'd25 + {3'b0, drop_lo} - {1'b0, cw_q};
	assign nl         = plen_q + 8'd1;
	assign heap_need  = (HFW+1)'(hfill_q) + (HFW+1)'(nl) + (HFW+1)'(1);
	assign push_ext   = {32'b0, in_ch.data.packed_byte} << bcnt_q;
	assign lit        = 8'(code_q - 24'd4);
	assign accept     = in_ch.valid && in_ch.ready;

	assign in_ch.ready  = (state_q == S_IDLE) && !ovalid_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = oword_q;

	// Sequencer: next state, datapath and memory controls
	always_comb begin
		state_d = state_q; phase_d = phase_q; buf_d = buf_q; bcnt_d = bcnt_q;
		cw_d = cw_q; ecnt_d = ecnt_q; hfill_d = hfill_q; plen_d = plen_q;
		pend_d = pend_q; run_d = run_q; recent_d = recent_q; opos_d = opos_q;
		sigm_d = sigm_q; hidx_d = hidx_q; skip_d = skip_q; rsym_d = rsym_q;
		rwid_d = rwid_q; fcode_d = fcode_q; code_d = code_q; before_d = before_q;
		ch_d = ch_q; off_d = off_q; idx_d = idx_q; acc_d = acc_q; n_d = n_q;
		ovalid_d = ovalid_q; oword_d = oword_q;
		heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_ra = '0;
		eo_we = 1'b0; eo_wa = '0; eo_wd = '0; eo_ra = '0;
		ps_we = 1'b0; ps_wa = '0; ps_wd = '0; ps_ra = '0;
		sh_amt = '0; take_w = '0;
		emit_en = 1'b0; emit_b = '0; fin = 1'b0;

		if (out_ch.valid && out_ch.ready)
			ovalid_d = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept && in_ch.data.func == FUNC_PULL) begin
					acc_d = '0;
					n_d = '0;
					state_d = S_LOOP;
				end else if (accept) begin
					// push: report a final status, check the header, skip, append to the bit buffer, or flag overflow
					oword_d = '0;
					oword_d.status = ST_OK;
					ovalid_d = 1'b1;
					if (phase_q == PH_FAIL)
						oword_d.status = fcode_q;
					else if (phase_q == PH_DONE)
						oword_d.status = ST_DONE;
					else if (phase_q == PH_HEADER) begin
						if (in_ch.data.packed_byte != hdr_byte(hidx_q[3:0])) begin
							phase_d = PH_FAIL; fcode_d = ST_BAD_HDR;
							run_d = '0; pend_d = '0;
							oword_d.status = ST_BAD_HDR;
						end else begin
							hidx_d = hidx_q + 5'd1;
							if (hidx_q + 5'd1 >= 5'd16)
								phase_d = PH_START;
						end
					end else if (skip_q >= 5'd8)
						skip_d = skip_q - 5'd8;
					else if (bcnt_q > 6'd32)
						oword_d.status = ST_OVERFLOW;
					else begin
						buf_d = buf_q | push_ext;
						bcnt_d = bcnt_q + 6'd8;
					end
				end
			end

			S_LOOP: begin
				if (n_q == 4'd8)
					fin = 1'b1;
				else if (run_q != '0) begin
					emit_en = 1'b1;
					emit_b = recent_q[{rsym_q, 3'b000} +: 8];
					run_d = run_q - 35'd1;
				end else if (pend_q != '0) begin
					ps_ra = pend_q;
					state_d = S_PEND;
				end else if (phase_q == PH_HEADER || phase_q == PH_DONE ||
				             phase_q == PH_FAIL)
					fin = 1'b1;
				else begin
					// decode one code or run field through the shared shifter
					case (phase_q)
						PH_RUN_LEN, PH_RUN_WID: take_w = 6'd2;
						PH_RUN_CNT:             take_w = rwid_q;
						default:                take_w = {1'b0, cw_q};
					endcase
					sh_amt = take_w;
					if (!take_ok)
						fin = 1'b1;
					else begin
						buf_d = sh_out;
						bcnt_d = bcnt_q - take_w;
						before_d = bcnt_q;
						code_d = take_v[23:0];
						case (phase_q)
							PH_START: begin
								if ({1'b0, take_v[23:0]} >= next_code) begin
									phase_d = PH_FAIL; fcode_d = ST_OVERFLOW;
									run_d = '0; pend_d = '0;
								end else begin
									phase_d = PH_NORMAL;
									state_d = S_TR;
								end
							end
							PH_NORMAL: begin
								if (take_v[23:0] == CODE_END)
									phase_d = PH_DONE;
								else if (take_v[23:0] == CODE_RESET)
									state_d = S_BRST;
								else if (take_v[23:0] == CODE_WIDEN) begin
									if (cw_q >= MAX_WIDTH) begin
										phase_d = PH_FAIL; fcode_d = ST_OVERFLOW;
										run_d = '0; pend_d = '0;
									end else
										cw_d = cw_q + 5'd1;
								end else if (take_v[23:0] == CODE_RUN)
									phase_d = PH_RUN_LEN;
								else
									state_d = S_LZW;
							end
							PH_RUN_LEN: begin
								rsym_d = take_v[1:0];
								phase_d = PH_RUN_WID;
							end
							PH_RUN_WID: begin
								rwid_d = 6'd4 << take_v[1:0];
								phase_d = PH_RUN_CNT;
							end
							default: begin
								run_d = 35'({3'b0, take_v} * {1'b0, rsym_q} +
								            {3'b0, take_v});
								phase_d = PH_START;
							end
						endcase
					end
				end
			end

			S_PEND: begin
				emit_en = 1'b1;
				emit_b = ps_rd_q;
				pend_d = (pend_q >= plen_q) ? 8'd0 : pend_q + 8'd1;
				state_d = S_LOOP;
			end

			// extension character of the new entry
			S_LZW: begin
				if ({1'b0, code_q} > next_code) begin
					phase_d = PH_FAIL; fcode_d = ST_OVERFLOW;
					run_d = '0; pend_d = '0;
					state_d = S_LOOP;
				end else if ({1'b0, code_q} == next_code) begin
					ps_ra = 8'd1;
					state_d = S_CH_PS;
				end else if (code_q < FIRST_ENTRY) begin
					ch_d = lit;
					state_d = S_APPEND;
				end else begin
					eo_ra = DAW'(code_q - FIRST_ENTRY);
					state_d = S_CH_OFF;
				end
			end

			S_CH_PS: begin
				ch_d = ps_rd_q;
				state_d = S_APPEND;
			end

			S_CH_OFF: begin
				heap_ra = eo_rd_q + HAW'(1);
				state_d = S_CH_HEAP;
			end

			S_CH_HEAP: begin
				ch_d = heap_rd_q;
				state_d = S_APPEND;
			end

			// grow previous string and check room for a new entry
			S_APPEND: begin
				if (plen_q >= STR_LIM || ecnt_q >= DICT_LIM || heap_need > HEAP_LIM) begin
					phase_d = PH_FAIL; fcode_d = ST_OVERFLOW;
					run_d = '0; pend_d = '0;
					state_d = S_LOOP;
				end else begin
					plen_d = nl;
					ps_we = 1'b1; ps_wa = nl; ps_wd = ch_q;
					heap_we = 1'b1; heap_wa = HAW'(hfill_q); heap_wd = nl;
					idx_d = 8'd1;
					state_d = S_CP_RD;
				end
			end

			S_CP_RD: begin
				ps_ra = idx_q;
				state_d = S_CP_WR;
			end

			S_CP_WR: begin
				heap_we = 1'b1;
				heap_wa = HAW'(hfill_q + HFW'(idx_q));
				heap_wd = ps_rd_q;
				if (idx_q == plen_q) begin
					eo_we = 1'b1; eo_wa = DAW'(ecnt_q); eo_wd = HAW'(hfill_q);
					ecnt_d = ecnt_q + EW'(1);
					hfill_d = hfill_q + HFW'(plen_q) + HFW'(1);
					state_d = S_TR;
				end else begin
					idx_d = idx_q + 8'd1;
					state_d = S_CP_RD;
				end
			end

			// translate the code into the previous-string buffer
			S_TR: begin
				if (code_q < FIRST_ENTRY) begin
					plen_d = 8'd1;
					ps_we = 1'b1; ps_wa = 8'd1; ps_wd = lit;
					pend_d = 8'd1;
					state_d = S_LOOP;
				end else begin
					eo_ra = DAW'(code_q - FIRST_ENTRY);
					state_d = S_TR_OFF;
				end
			end

			S_TR_OFF: begin
				off_d = eo_rd_q;
				heap_ra = eo_rd_q;
				state_d = S_TR_LEN;
			end

			S_TR_LEN: begin
				plen_d = heap_rd_q;
				idx_d = 8'd1;
				if (heap_rd_q == '0) begin
					pend_d = 8'd1;
					state_d = S_LOOP;
				end else
					state_d = S_TR_RD;
			end

			S_TR_RD: begin
				heap_ra = off_q + HAW'(idx_q);
				state_d = S_TR_WR;
			end

			S_TR_WR: begin
				ps_we = 1'b1; ps_wa = idx_q; ps_wd = heap_rd_q;
				if (idx_q == plen_q) begin
					pend_d = 8'd1;
					state_d = S_LOOP;
				end else begin
					idx_d = idx_q + 8'd1;
					state_d = S_TR_RD;
				end
			end

			// block reset: drop the prefetch look-ahead and empty the dictionary
			S_BRST: begin
				sh_amt = drop;
				if (bcnt_q >= drop) begin
					buf_d = sh_out;
					bcnt_d = bcnt_q - drop;
				end else begin
					skip_d = 5'(drop - bcnt_q);
					buf_d = '0;
					bcnt_d = '0;
				end
				cw_d = START_WIDTH;
				ecnt_d = '0;
				hfill_d = '0;
				phase_d = PH_START;
				state_d = S_LOOP;
			end

			default: state_d = S_IDLE;
		endcase

		// byte out: pack, history, signature check
		if (emit_en) begin
			acc_d[{n_q[2:0], 3'b000} +: 8] = emit_b;
			n_d = n_q + 4'd1;
			recent_d = {recent_q[23:0], emit_b};
			if (opos_q >= SIG_OFFSET && opos_q < SIG_END &&
			    sig_byte(5'(opos_q - SIG_OFFSET)) != emit_b)
				sigm_d = 1'b0;
			if (opos_q < POS_MAX)
				opos_d = opos_q + 12'd1;
		end

		// pull result
		if (fin) begin
			oword_d = '0;
			ovalid_d = 1'b1;
			state_d = S_IDLE;
			if (phase_q == PH_FAIL)
				oword_d.status = fcode_q;
			else if (n_q != '0) begin
				oword_d.status = ST_OK;
				oword_d.out_bytes = acc_q;
				oword_d.out_count = n_q;
			end else if (phase_q == PH_DONE) begin
				oword_d.status = ST_DONE;
				oword_d.signature_ok = sigm_q && (opos_q >= SIG_END);
			end else
				oword_d.status = ST_NEED;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; phase_q <= PH_HEADER; buf_q <= '0; bcnt_q <= '0;
			cw_q <= START_WIDTH; ecnt_q <= '0; hfill_q <= '0; plen_q <= '0;
			pend_q <= '0; run_q <= '0; recent_q <= '0; opos_q <= '0;
			sigm_q <= 1'b1; hidx_q <= '0; skip_q <= '0; rsym_q <= '0;
			rwid_q <= '0; fcode_q <= ST_OK; ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d; phase_q <= phase_d; buf_q <= buf_d; bcnt_q <= bcnt_d;
			cw_q <= cw_d; ecnt_q <= ecnt_d; hfill_q <= hfill_d; plen_q <= plen_d;
			pend_q <= pend_d; run_q <= run_d; recent_q <= recent_d; opos_q <= opos_d;
			sigm_q <= sigm_d; hidx_q <= hidx_d; skip_q <= skip_d; rsym_q <= rsym_d;
			rwid_q <= rwid_d; fcode_q <= fcode_d; ovalid_q <= ovalid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		code_q <= code_d; before_q <= before_d; ch_q <= ch_d; off_q <= off_d;
		idx_q <= idx_d; acc_q <= acc_d; n_q <= n_d; oword_q <= oword_d;
	end

	// String heap
	always_ff @(posedge clk) begin
		if (heap_we)
			heap_q[heap_wa] <= heap_wd;
		heap_rd_q <= heap_q[heap_ra];
	end

	// Entry offsets
	always_ff @(posedge clk) begin
		if (eo_we)
			eo_q[eo_wa] <= eo_wd;
		eo_rd_q <= eo_q[eo_ra];
	end

	// Previous string
	always_ff @(posedge clk) begin
		if (ps_we)
			ps_q[ps_wa] <= ps_wd;
		ps_rd_q <= ps_q[ps_ra];
	end

endmodule
